[rtl/core/lhme_pkg.sv]
// Shared types and defaults for the LSB Hamming matrix embedding unit.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package lhme_pkg;

  // Default code geometry: Hamming code of length 7 with 3 syndrome bits
  localparam int CodeLengthDef   = 7;
  localparam int SyndromeBitsDef = 3;

  localparam int ByteW = 8;
  localparam int MsgW  = 3;
  localparam int IdxW  = 4;

  localparam logic [IdxW-1:0] IndexMax = 4'd15;

  typedef struct packed {
    logic [ByteW-1:0] cover_byte;
    logic [MsgW-1:0]  message_triplet;
    logic             last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] stego_byte;
    logic             last_of_run;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/core/lhme_out_skid.sv]
// Two-entry output queue that decouples block-buffer reads from the output stall.
// Depends on lhme_pkg for the output beat type.
`default_nettype none

module lhme_out_skid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire lhme_pkg::out_beat_t push_data_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output lhme_pkg::out_beat_t     data_o,
  output logic                    pop_o,
  output logic [1:0]              level_o
);

  lhme_pkg::out_beat_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;
  assign pop_o   = pop;
  assign level_o = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lsb_hamming_matrix_embed_unit.sv]
// Top level of the LSB Hamming matrix embedding unit: ping-pong block memory,
// syndrome tracking and flip selection. Depends on lhme_pkg and lhme_out_skid.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid / stall   | cover byte, message, last
//   out     | output    | out_valid / stall  | stego byte, last of run
//   cfg     | input     | cfg_valid / ready  | message block count
//
// Sustains one byte per cycle on both sides while the output does not stall. Bytes
// are written into one of two block banks in a 2*CODE_LENGTH entry memory; a closed
// block drains from its bank while the next block fills the other bank. Output bytes
// pass through the registered memory read and then the output queue. The input
// stalls only while the bank it would write is still draining.
// Reset clears all control state; the memory needs no clearing.
`default_nettype none

module lsb_hamming_matrix_embed_unit #(
  parameter int CODE_LENGTH   = lhme_pkg::CodeLengthDef,
  parameter int SYNDROME_BITS = lhme_pkg::SyndromeBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lhme_pkg::in_beat_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lhme_pkg::out_beat_t       out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [lhme_pkg::MsgW-1:0] cfg_data_i
);

  localparam int CntW  = $clog2(CODE_LENGTH + 1);
  localparam int AddrW = $clog2(2 * CODE_LENGTH);
  localparam int FlipW = (CntW > lhme_pkg::MsgW) ? CntW : lhme_pkg::MsgW;
  localparam int Depth = 2 * CODE_LENGTH;
  localparam logic [CntW-1:0] CodeLen = CntW'(CODE_LENGTH);
  localparam logic [AddrW-1:0] BankOfs = AddrW'(CODE_LENGTH);
  localparam logic [lhme_pkg::MsgW-1:0] MsgMask =
    lhme_pkg::MsgW'((1 << SYNDROME_BITS) - 1);

  // Configuration register
  logic [lhme_pkg::MsgW-1:0] cfg_q;

  // Write side
  logic                      wr_bank_q;
  logic [CntW-1:0]           fill_q, fill_d;
  logic [CntW-1:0]           syn_q, syn_d;
  logic [lhme_pkg::MsgW-1:0] held_q;
  logic [lhme_pkg::IdxW-1:0] idx_q, idx_d;

  // Per-bank block descriptors
  logic [1:0]                bank_full_q, bank_full_d;
  logic [CntW-1:0]           bank_cnt_q  [2];
  logic [FlipW-1:0]          bank_flip_q [2];

  // Read side
  logic                      rd_bank_q;
  logic [CntW-1:0]           rd_ptr_q;
  logic                      rv_q, rv_flip_q, rv_last_q;
  logic [lhme_pkg::ByteW-1:0] rdata_q;

  logic [lhme_pkg::ByteW-1:0] mem_q [Depth];

  logic                      in_acc;
  logic [CntW-1:0]           pos;
  logic [CntW-1:0]           syn_new;
  logic                      close;
  logic [lhme_pkg::MsgW-1:0] msg_in_m, held_eff, msg;
  logic                      due;
  logic [FlipW-1:0]          flip;
  logic [FlipW-1:0]          flip_sel;
  logic [AddrW-1:0]          wr_addr, rd_addr;

  logic                      rd_issue;
  logic [CntW-1:0]           rd_pos;
  logic                      rd_last, rd_flip;
  logic [1:0]                occ;
  logic                      issue_ok;

  lhme_pkg::out_beat_t       push_data;
  logic                      q_pop;
  logic [1:0]                q_level;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = bank_full_q[wr_bank_q];
  assign in_acc      = in_valid_i && !in_stall_o;

  // Syndrome and flip position for the block being filled
  always_comb begin
    pos      = fill_q + CntW'(1);
    syn_new  = syn_q ^ (in_data_i.cover_byte[0] ? pos : '0);
    close    = in_acc && ((pos == CodeLen) || in_data_i.last_byte);
    msg_in_m = in_data_i.message_triplet & MsgMask;
    held_eff = (fill_q == '0) ? msg_in_m : held_q;
    due      = 1'b1;
    msg      = '0;
    if (idx_q == '0) begin
      msg = cfg_q & MsgMask;
    end else if ({1'b0, cfg_q} >= idx_q) begin
      msg = held_eff;
    end else begin
      due = 1'b0;
    end
    flip     = FlipW'(syn_new) ^ FlipW'(msg);
    // flip position zero or past the real bytes flips nothing
    flip_sel = (due && (flip != '0) && (flip <= FlipW'(pos))) ? flip : '0;
    wr_addr  = wr_bank_q ? (AddrW'(fill_q) + BankOfs) : AddrW'(fill_q);
  end

  always_comb begin
    fill_d = fill_q;
    syn_d  = syn_q;
    idx_d  = idx_q;
    if (in_acc) begin
      if (close) begin
        fill_d = '0;
        syn_d  = '0;
        if (in_data_i.last_byte) begin
          idx_d = '0;
        end else if (idx_q != lhme_pkg::IndexMax) begin
          idx_d = idx_q + lhme_pkg::IdxW'(1);
        end
      end else begin
        fill_d = pos;
        syn_d  = syn_new;
      end
    end
  end

  // Read scheduling: keep queue level plus in-flight read within two entries
  always_comb begin
    occ      = q_level + {1'b0, rv_q};
    issue_ok = (occ < 2'd2) || ((occ == 2'd2) && q_pop);
    rd_issue = bank_full_q[rd_bank_q] && issue_ok;
    rd_pos   = rd_ptr_q + CntW'(1);
    rd_last  = (rd_pos == bank_cnt_q[rd_bank_q]);
    rd_flip  = (FlipW'(rd_pos) == bank_flip_q[rd_bank_q]);
    rd_addr  = rd_bank_q ? (AddrW'(rd_ptr_q) + BankOfs) : AddrW'(rd_ptr_q);
  end

  // hand the closed bank to the read side, release the drained one
  always_comb begin
    bank_full_d = bank_full_q;
    if (close) begin
      bank_full_d[wr_bank_q] = 1'b1;
    end
    if (rd_issue && rd_last) begin
      bank_full_d[rd_bank_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      wr_bank_q   <= 1'b0;
      fill_q      <= '0;
      syn_q       <= '0;
      held_q      <= '0;
      idx_q       <= '0;
      bank_full_q <= 2'b00;
      rd_bank_q   <= 1'b0;
      rd_ptr_q    <= '0;
      rv_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      fill_q      <= fill_d;
      syn_q       <= syn_d;
      idx_q       <= idx_d;
      bank_full_q <= bank_full_d;
      if (in_acc && (fill_q == '0)) begin
        held_q <= msg_in_m;
      end
      if (close) begin
        wr_bank_q <= ~wr_bank_q;
      end
      rv_q <= rd_issue;
      if (rd_issue) begin
        if (rd_last) begin
          rd_bank_q <= ~rd_bank_q;
          rd_ptr_q  <= '0;
        end else begin
          rd_ptr_q <= rd_pos;
        end
      end
    end
  end

  // Descriptor payload and read metadata
  always_ff @(posedge clk_i) begin
    if (close) begin
      bank_cnt_q[wr_bank_q]  <= pos;
      bank_flip_q[wr_bank_q] <= flip_sel;
    end
    if (rd_issue) begin
      rv_flip_q <= rd_flip;
      rv_last_q <= rd_last;
    end
  end

  // Block memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[wr_addr] <= in_data_i.cover_byte;
    end
    if (rd_issue) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    push_data.stego_byte  = rdata_q ^ {{(lhme_pkg::ByteW-1){1'b0}}, rv_flip_q};
    push_data.last_of_run = rv_last_q;
  end

  lhme_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rv_q),
    .push_data_i (push_data),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_data_o),
    .pop_o       (q_pop),
    .level_o     (q_level)
  );

endmodule

`default_nettype wire

[rtl/core/lhme_checker.sv]
// Port-level checker for the LSB Hamming matrix embedding unit, bound to the top.
// Depends on lhme_pkg for the beat types.
`default_nettype none

module lhme_checker #(
  parameter int CODE_LENGTH = lhme_pkg::CodeLengthDef
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire lhme_pkg::out_beat_t  out_data_o
);

  localparam int OutsW  = $clog2(2 * CODE_LENGTH + 4) + 1;
  localparam int RunW   = $clog2(CODE_LENGTH + 1);
  localparam logic [OutsW-1:0] OutsMax = OutsW'(2 * CODE_LENGTH + 3);
  localparam logic [RunW-1:0]  RunMax  = RunW'(CODE_LENGTH);

  logic             in_acc, out_acc;
  logic [OutsW-1:0] outs_q;
  logic [RunW-1:0]  run_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // bytes taken but not yet delivered, and bytes delivered in the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outs_q <= '0;
      run_q  <= '0;
    end else begin
      outs_q <= outs_q + {{(OutsW-1){1'b0}}, in_acc} - {{(OutsW-1){1'b0}}, out_acc};
      if (out_acc) begin
        run_q <= out_data_o.last_of_run ? '0 : run_q + RunW'(1);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (outs_q != '0) || in_acc)
    else $error("output beat without a pending input byte");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outs_q <= OutsMax)
    else $error("more bytes buffered than two blocks can hold");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (run_q < RunMax))
    else $error("run longer than one code block");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (outs_q != '0))
    else $error("input stalled with nothing buffered");

endmodule

bind lsb_hamming_matrix_embed_unit lhme_checker #(
  .CODE_LENGTH (CODE_LENGTH)
) u_lhme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for lsb_hamming_matrix_embed_unit: directed table, then random images.
// Depends on lhme_pkg and the unit RTL only; predicts stego bytes in-bench.
module tb_top;

  localparam int BlkLen     = lhme_pkg::CodeLengthDef;
  localparam int CycleLimit = 100000;
  localparam int HoldCycles = 120;
  localparam int RandItems  = 140;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    lhme_pkg::in_beat_t            beat;
    logic [lhme_pkg::MsgW-1:0]     blocks;  // register value on ROW_CFG rows
    logic                          typed;
    lhme_pkg::out_beat_t           want;
  } stim_row_t;

  localparam int DirRows = 26;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  lhme_pkg::in_beat_t        in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  lhme_pkg::out_beat_t       out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [lhme_pkg::MsgW-1:0] cfg_data  = '0;

  // Block model state
  logic [lhme_pkg::ByteW-1:0] blk_mem [BlkLen];
  int unsigned                blk_fill   = 0;
  logic [lhme_pkg::IdxW-1:0]  blk_idx    = '0;
  logic [lhme_pkg::MsgW-1:0]  held_msg   = '0;
  logic [lhme_pkg::MsgW-1:0]  msg_blocks = '0;
  lhme_pkg::out_beat_t        stego_q [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          gapless     = 1'b0;
  logic        hold_req    = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned rx_mode     = 0;
  int unsigned rx_left     = 0;

  stim_row_t dir_rows [DirRows] = '{
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b1}, 3'd0, 1'b1, '{8'hFE, 1'b1}},
    '{ROW_BEAT, '{8'h00, 3'd0, 1'b1}, 3'd0, 1'b1, '{8'h00, 1'b1}},
    '{ROW_CFG,  '{8'h00, 3'd0, 1'b0}, 3'd7, 1'b0, '{8'h00, 1'b0}},
    // full header block, then a partial message block
    '{ROW_BEAT, '{8'h00, 3'd5, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'h01, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFE, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'h80, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'h7F, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'h55, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hAA, 3'd7, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'h03, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b1}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    // partial header whose flip lands past the real bytes
    '{ROW_BEAT, '{8'h00, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'h00, 3'd0, 1'b1}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_CFG,  '{8'h00, 3'd0, 1'b0}, 3'd1, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'h01, 3'd0, 1'b1}, 3'd0, 1'b1, '{8'h01, 1'b1}},
    '{ROW_CFG,  '{8'h00, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd3, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    '{ROW_BEAT, '{8'hFF, 3'd0, 1'b0}, 3'd0, 1'b0, '{8'h00, 1'b0}},
    // block past the count passes through
    '{ROW_BEAT, '{8'hFE, 3'd7, 1'b1}, 3'd0, 1'b1, '{8'hFE, 1'b1}}
  };

  lsb_hamming_matrix_embed_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d stego beats still expected", $time, stego_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Collect one byte into the block; on close, embed and queue the block's stego beats.
  function automatic void embed_predict(input lhme_pkg::in_beat_t b);
    logic [lhme_pkg::MsgW-1:0] syn;
    logic [lhme_pkg::MsgW-1:0] code;
    logic [lhme_pkg::MsgW-1:0] flip;
    bit                        due;
    int unsigned               n;
    int                        i;
    lhme_pkg::out_beat_t       ob;
    if (blk_fill == 0) held_msg = b.message_triplet;
    blk_mem[blk_fill] = b.cover_byte;
    blk_fill++;
    if (blk_fill < BlkLen && !b.last_byte) return;
    n   = blk_fill;
    syn = '0;
    for (i = 0; i < n; i++)
      if (blk_mem[i][0]) syn ^= lhme_pkg::MsgW'(i + 1);
    due = 1'b1;
    if (blk_idx == 0) begin
      code = msg_blocks;
    end else if (blk_idx <= msg_blocks) begin
      code = held_msg;
    end else begin
      code = '0;
      due  = 1'b0;
    end
    flip = syn ^ code;
    if (due && flip >= 1 && flip <= n) blk_mem[flip - 1][0] = ~blk_mem[flip - 1][0];
    for (i = 0; i < n; i++) begin
      ob.stego_byte  = blk_mem[i];
      ob.last_of_run = (i + 1 == n);
      stego_q.insert(stego_q.size(), ob);
    end
    blk_fill = 0;
    if (b.last_byte) blk_idx = '0;
    else if (blk_idx < lhme_pkg::IndexMax) blk_idx++;
  endfunction

  // Offer one cover beat, idling between bursts unless gapless; hold it until the unit takes it.
  task automatic put_byte(input lhme_pkg::in_beat_t b, input bit typed,
                          input lhme_pkg::out_beat_t want);
    if (!gapless && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    embed_predict(b);
    if (typed) begin
      stego_q[stego_q.size() - 1] = want;
    end
  endtask

  // Stop sending and wait until every expected beat has come out.
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stego_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_blocks(input logic [lhme_pkg::MsgW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    msg_blocks = v;
  endtask

  // Output side: check every accepted beat, stall on a pattern of its own.
  always @(posedge clk) begin : rx_side
    lhme_pkg::out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (stego_q.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          error_count++;
        end else begin
          want = stego_q.pop_front();
          if (out_data.stego_byte !== want.stego_byte) begin
            $display("%0t: stego_byte expected %h got %h", $time, want.stego_byte,
                     out_data.stego_byte);
            error_count++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b got %b", $time, want.last_of_run,
                     out_data.last_of_run);
            error_count++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(20, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          2:       out_stall <= (rx_left % 4 == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int                        r;
    int unsigned               k;
    int unsigned               phase;
    int unsigned               n_rand;
    int unsigned               img_len;
    logic [lhme_pkg::MsgW-1:0] cfg_v;
    bit                        drop_last;
    lhme_pkg::in_beat_t        b;
    n_rand = 0;
    phase  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DirRows; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain_wait();
        write_blocks(dir_rows[r].blocks);
      end else begin
        put_byte(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Random images: header block, message blocks, pass-through tail
    while (n_rand < RandItems) begin
      drain_wait();
      case (phase % 4)
        0:       cfg_v = 3'd7;
        1:       cfg_v = 3'd0;
        default: cfg_v = 3'($urandom_range(0, 7));
      endcase
      // a partial block still held in the unit keeps the old count
      if (blk_fill == 0) write_blocks(cfg_v);
      gapless = (phase % 3 != 0);
      if (phase == 1) begin
        // back up the output so the unit fills and stalls its input
        hold_req <= ~hold_req;
        img_len = 24;
      end else if (phase == 2) begin
        // long image: block index must saturate, not wrap to a header
        img_len = BlkLen * 17 + $urandom_range(0, 6);
      end else if ($urandom_range(0, 4) == 0) begin
        img_len = $urandom_range(1, 3);
      end else begin
        img_len = BlkLen * $urandom_range(1, 3) + $urandom_range(0, 6);
      end
      drop_last = (phase != 2) && ($urandom_range(0, 3) == 0);
      for (k = 0; k < img_len; k++) begin
        b.cover_byte      = 8'($urandom);
        b.message_triplet = 3'($urandom);
        b.last_byte       = (k == img_len - 1) && !drop_last;
        if (phase != 2 && $urandom_range(0, 29) == 0) b.last_byte = 1'b1;
        put_byte(b, 1'b0, '0);
        n_rand++;
      end
      phase++;
    end

    drain_wait();
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lhme_pkg.sv
rtl/core/lhme_out_skid.sv
rtl/core/lsb_hamming_matrix_embed_unit.sv
rtl/core/lhme_checker.sv
sim/tb_top.sv
